// ===== hdl/scc_pkg.sv =====
// Package with shared types, constants and state codes for the SCC unit.
package scc_pkg;

    localparam int MaxVertices = 16;
    localparam int VertexBits  = 4;
    localparam int CountBits   = 5;

    localparam logic KIND_EDGE = 1'b0;
    localparam logic KIND_RUN  = 1'b1;

    localparam logic [0:0] REG_VERTEX_COUNT = 1'b0;

    typedef struct packed {
        logic                  kind;
        logic [VertexBits-1:0] from_vertex;
        logic [VertexBits-1:0] to_vertex;
    } scc_in_t;

    typedef struct packed {
        logic [VertexBits-1:0] vertex_index;
        logic [VertexBits-1:0] component_id;
        logic [CountBits-1:0]  component_count;
        logic                  last_item;
    } scc_out_t;

    // Sequencer states.
    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_F_ROOT  = 4'd1;
    localparam logic [3:0] ST_F_STEP  = 4'd2;
    localparam logic [3:0] ST_R_ROOT  = 4'd3;
    localparam logic [3:0] ST_R_STEP  = 4'd4;
    localparam logic [3:0] ST_EMIT    = 4'd5;

    // Control word from sequencer to the shared neighbour search unit.
    typedef struct packed {
        logic [MaxVertices-1:0] row;
        logic [MaxVertices-1:0] visited;
        logic [CountBits-1:0]   from_pos;
        logic [CountBits-1:0]   limit;
    } scc_search_t;

    typedef struct packed {
        logic                  found;
        logic [VertexBits-1:0] pos;
    } scc_found_t;

endpackage

// ===== hdl/scc_search.sv =====
// Shared neighbour search: lowest unvisited neighbour at or above a start position.
module scc_search
    import scc_pkg::*;
(
    input  scc_search_t req,
    output scc_found_t  res
);

    logic [MaxVertices-1:0] cand;

    // Mask of candidate neighbours, then a priority pick of the lowest one.
    always_comb
    begin
        res = '0;
        for (int i = 0; i < MaxVertices; i++)
        begin
            cand[i] = req.row[i] && !req.visited[i]
                      && (CountBits'(i) >= req.from_pos) && (CountBits'(i) < req.limit);
        end
        for (int i = MaxVertices - 1; i >= 0; i--)
        begin
            if (cand[i])
            begin
                res.found = 1'b1;
                res.pos   = VertexBits'(i);
            end
        end
    end

endmodule

// ===== hdl/strongly_connected_components_unit.sv =====
// Top level of the strongly connected components unit with its sequencer.
// Usage:
// An item is a command word on cmd, taken when start is high and busy is low.
// An edge command sets one bit in each adjacency matrix; it gives no
// result word. An edge naming a vertex at or above the effective vertex
// count is dropped. A run command walks the graph with Kosaraju's method:
// a forward depth-first walk records finish order, then reverse walks in
// reverse finish order number the components. Each walk step is one use
// of the shared neighbour search unit. After the walks, during emission one
// result word per vertex appears on res for one cycle with res_valid high;
// the last carries last_item. The receiver cannot stall; results are never
// held. busy is high throughout a run. Reset clears the graph, sets the
// vertex count register to 16 and returns the sequencer to idle. The vertex
// count register lies at APB address 0; the user must write it only while
// idle, as the block itself does not enforce this.
module strongly_connected_components_unit
    import scc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  scc_in_t     cmd,
    output logic        res_valid,
    output scc_out_t    res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [CountBits-1:0]   vcount_reg;
    logic [MaxVertices-1:0] fwd_reg [MaxVertices];
    logic [MaxVertices-1:0] rev_reg [MaxVertices];
    logic [MaxVertices-1:0] visited_reg;
    logic [VertexBits-1:0]  finish_reg [MaxVertices];
    logic [VertexBits-1:0]  comp_reg [MaxVertices];
    logic [VertexBits-1:0]  stk_v_reg [MaxVertices];
    logic [CountBits-1:0]   stk_w_reg [MaxVertices];
    logic [CountBits-1:0]   depth_reg;
    logic [CountBits-1:0]   fcount_reg;
    logic [CountBits-1:0]   idx_reg;
    logic [CountBits-1:0]   k_reg;
    logic [3:0]             state_reg;
    logic [CountBits-1:0]   n_eff;
    logic                   accept;
    logic                   cfg_wr;
    scc_search_t            sreq;
    scc_found_t             sres;
    logic [VertexBits-1:0]  top_v;
    logic [VertexBits-1:0]  top_i;
    logic [VertexBits-1:0]  root_v;
    logic                   fwd_pass;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == {REG_VERTEX_COUNT, 1'b0});
    assign prdata = (paddr == {REG_VERTEX_COUNT, 1'b0}) ? {27'd0, vcount_reg} : 32'd0;
    assign accept = start && !busy;
    assign busy   = (state_reg != ST_IDLE);

    // Effective vertex count, saturated to one at the bottom and to 16 at the top.
    assign n_eff = (vcount_reg == '0) ? CountBits'(1)
                 : (vcount_reg > CountBits'(MaxVertices)) ? CountBits'(MaxVertices)
                 : vcount_reg;

    // Inputs to the shared search unit, taken from the top of the walk stack.
    assign top_i    = VertexBits'(depth_reg - CountBits'(1));
    assign top_v    = stk_v_reg[top_i];
    assign fwd_pass = (state_reg == ST_F_STEP);
    always_comb
    begin
        sreq.row      = fwd_pass ? fwd_reg[top_v] : rev_reg[top_v];
        sreq.visited  = visited_reg;
        sreq.from_pos = stk_w_reg[top_i];
        sreq.limit    = n_eff;
    end

    scc_search u_search (
        .req (sreq),
        .res (sres)
    );

    assign root_v = finish_reg[VertexBits'(idx_reg - CountBits'(1))];

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vcount_reg <= CountBits'(16);
        else if (cfg_wr)
            vcount_reg <= pwdata[CountBits-1:0];
    end

    // Adjacency matrices.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MaxVertices; i++)
            begin
                fwd_reg[i] <= '0;
                rev_reg[i] <= '0;
            end
        end
        else if (accept && cmd.kind == KIND_EDGE
                 && {1'b0, cmd.from_vertex} < n_eff && {1'b0, cmd.to_vertex} < n_eff)
        begin
            fwd_reg[cmd.from_vertex][cmd.to_vertex] <= 1'b1;
            rev_reg[cmd.to_vertex][cmd.from_vertex] <= 1'b1;
        end
    end

    // Walk stores need no reset: every entry is written before it is read.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_F_ROOT:
            begin
                if (!visited_reg[VertexBits'(idx_reg)] && idx_reg < n_eff)
                begin
                    stk_v_reg[0] <= VertexBits'(idx_reg);
                    stk_w_reg[0] <= '0;
                end
            end
            ST_R_ROOT:
            begin
                if (idx_reg != '0 && !visited_reg[root_v])
                begin
                    stk_v_reg[0] <= root_v;
                    stk_w_reg[0] <= '0;
                    comp_reg[root_v] <= VertexBits'(k_reg);
                end
            end
            ST_F_STEP, ST_R_STEP:
            begin
                if (sres.found && depth_reg < CountBits'(MaxVertices))
                begin
                    stk_w_reg[top_i] <= CountBits'(sres.pos) + CountBits'(1);
                    stk_v_reg[VertexBits'(depth_reg)] <= sres.pos;
                    stk_w_reg[VertexBits'(depth_reg)] <= '0;
                    if (!fwd_pass)
                        comp_reg[sres.pos] <= VertexBits'(k_reg);
                end
                else if (fwd_pass)
                    finish_reg[VertexBits'(fcount_reg)] <= top_v;
            end
            default:
            begin
            end
        endcase
    end

    // Sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            visited_reg <= '0;
            depth_reg   <= '0;
            fcount_reg  <= '0;
            idx_reg     <= '0;
            k_reg       <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept && cmd.kind == KIND_RUN)
                    begin
                        visited_reg <= '0;
                        fcount_reg  <= '0;
                        idx_reg     <= '0;
                        depth_reg   <= '0;
                        state_reg   <= ST_F_ROOT;
                    end
                end
                ST_F_ROOT:
                begin
                    if (idx_reg >= n_eff)
                    begin
                        visited_reg <= '0;
                        idx_reg     <= fcount_reg;
                        k_reg       <= '0;
                        state_reg   <= ST_R_ROOT;
                    end
                    else if (visited_reg[VertexBits'(idx_reg)])
                        idx_reg <= idx_reg + CountBits'(1);
                    else
                    begin
                        visited_reg[VertexBits'(idx_reg)] <= 1'b1;
                        depth_reg <= CountBits'(1);
                        state_reg <= ST_F_STEP;
                    end
                end
                ST_R_ROOT:
                begin
                    if (idx_reg == '0)
                    begin
                        idx_reg   <= '0;
                        state_reg <= ST_EMIT;
                    end
                    else if (visited_reg[root_v])
                        idx_reg <= idx_reg - CountBits'(1);
                    else
                    begin
                        visited_reg[root_v] <= 1'b1;
                        depth_reg <= CountBits'(1);
                        state_reg <= ST_R_STEP;
                    end
                end
                ST_F_STEP, ST_R_STEP:
                begin
                    if (sres.found && depth_reg < CountBits'(MaxVertices))
                    begin
                        visited_reg[sres.pos] <= 1'b1;
                        depth_reg <= depth_reg + CountBits'(1);
                    end
                    else
                    begin
                        depth_reg <= depth_reg - CountBits'(1);
                        if (fwd_pass && fcount_reg < CountBits'(MaxVertices))
                            fcount_reg <= fcount_reg + CountBits'(1);
                        if (depth_reg == CountBits'(1))
                        begin
                            if (fwd_pass)
                            begin
                                idx_reg   <= idx_reg + CountBits'(1);
                                state_reg <= ST_F_ROOT;
                            end
                            else
                            begin
                                k_reg     <= k_reg + CountBits'(1);
                                idx_reg   <= idx_reg - CountBits'(1);
                                state_reg <= ST_R_ROOT;
                            end
                        end
                    end
                end
                ST_EMIT:
                begin
                    idx_reg <= idx_reg + CountBits'(1);
                    if (idx_reg + CountBits'(1) == n_eff)
                        state_reg <= ST_IDLE;
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    // Result word, driven straight from the emit state.
    assign res_valid           = (state_reg == ST_EMIT);
    assign res.vertex_index    = VertexBits'(idx_reg);
    assign res.component_id    = comp_reg[VertexBits'(idx_reg)];
    assign res.component_count = k_reg;
    assign res.last_item       = (idx_reg + CountBits'(1) == n_eff);

`ifndef SYNTHESIS
    // The walk stack never overflows its storage.
    assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= CountBits'(MaxVertices))
        else $error("walk stack depth out of range");

    // A result word is only given while busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> busy)
        else $error("result outside a run");

    // The last result word ends the run.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.last_item) |=> !busy)
        else $error("run continued after last word");
`endif

endmodule

// ===== tb/scc_checker.sv =====
// Checker for the SCC unit: predicts component labels and compares result words.
`timescale 1ns / 100ps

module scc_checker
    import scc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  scc_in_t     cmd,
    input  logic        res_valid,
    input  scc_out_t    res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          pending
);

    // Shadow copy of the graph and the vertex count register.
    logic [MaxVertices-1:0] fwd_rows [MaxVertices];
    logic [MaxVertices-1:0] rev_rows [MaxVertices];
    logic [CountBits-1:0]   vcount_shadow;

    // Working storage of the predicted walks.
    logic [MaxVertices-1:0] seen;
    int                     finish_list [MaxVertices];
    int                     finish_len;
    int                     label_of [MaxVertices];

    // Result words still to arrive, oldest first.
    scc_out_t               component_q [$];

    function automatic int active_vertices();
        int n;
        n = vcount_shadow;
        if (n < 1) n = 1;
        if (n > MaxVertices) n = MaxVertices;
        return n;
    endfunction

    // One depth-first walk with an explicit stack; neighbours in ascending order.
    task automatic walk_from(input bit forward_pass, input int root, input int n,
                             input int label);
        int  stack_v [MaxVertices];
        int  stack_next [MaxVertices];
        int  depth;
        int  u;
        int  w;
        bit  found;
        bit  edge_bit;
        seen[root] = 1'b1;
        if (!forward_pass) label_of[root] = label;
        stack_v[0] = root;
        stack_next[0] = 0;
        depth = 1;
        while (depth > 0)
        begin
            u = stack_v[depth-1];
            w = stack_next[depth-1];
            found = 1'b0;
            while (w < n && !found)
            begin
                edge_bit = forward_pass ? fwd_rows[u][w] : rev_rows[u][w];
                if (edge_bit && !seen[w]) found = 1'b1;
                else w++;
            end
            if (found && depth < MaxVertices)
            begin
                stack_next[depth-1] = w + 1;
                seen[w] = 1'b1;
                if (!forward_pass) label_of[w] = label;
                stack_v[depth] = w;
                stack_next[depth] = 0;
                depth++;
            end
            else
            begin
                depth--;
                if (forward_pass && finish_len < MaxVertices)
                begin
                    finish_list[finish_len] = u;
                    finish_len++;
                end
            end
        end
    endtask

    // Kosaraju over the active vertices; queues one word per vertex.
    task automatic predict_components();
        int       n;
        int       comps;
        int       u;
        scc_out_t word;
        n = active_vertices();
        seen = '0;
        finish_len = 0;
        for (int v = 0; v < n; v++)
            if (!seen[v]) walk_from(1'b1, v, n, 0);
        seen = '0;
        comps = 0;
        for (int i = finish_len; i > 0; i--)
        begin
            u = finish_list[i-1];
            if (!seen[u])
            begin
                walk_from(1'b0, u, n, comps);
                comps++;
            end
        end
        for (int v = 0; v < n; v++)
        begin
            word.vertex_index    = VertexBits'(v);
            word.component_id    = VertexBits'(label_of[v]);
            word.component_count = CountBits'(comps);
            word.last_item       = (v + 1 == n);
            component_q = {component_q, word};
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        scc_out_t want;
        int       n;
        if (!rst_n)
        begin
            for (int i = 0; i < MaxVertices; i++)
            begin
                fwd_rows[i] = '0;
                rev_rows[i] = '0;
            end
            vcount_shadow = CountBits'(16);
            component_q.delete();
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            // Register write.
            if (psel && penable && pwrite && pready && paddr == {1'b0, REG_VERTEX_COUNT})
                vcount_shadow = pwdata[CountBits-1:0];

            // Result word against the oldest prediction.
            if (res_valid)
            begin
                if (component_q.size() == 0)
                begin
                    $error("unexpected result word: vertex %0d", res.vertex_index);
                    fail_count++;
                end
                else
                begin
                    want = component_q.pop_front();
                    if (res.vertex_index !== want.vertex_index)
                    begin
                        $error("vertex_index: expected %0d, got %0d",
                               want.vertex_index, res.vertex_index);
                        fail_count++;
                    end
                    if (res.component_id !== want.component_id)
                    begin
                        $error("component_id: expected %0d, got %0d",
                               want.component_id, res.component_id);
                        fail_count++;
                    end
                    if (res.component_count !== want.component_count)
                    begin
                        $error("component_count: expected %0d, got %0d",
                               want.component_count, res.component_count);
                        fail_count++;
                    end
                    if (res.last_item !== want.last_item)
                    begin
                        $error("last_item: expected %0d, got %0d",
                               want.last_item, res.last_item);
                        fail_count++;
                    end
                end
            end

            // Accepted command word.
            if (start && !busy)
            begin
                if (cmd.kind == KIND_RUN)
                begin
                    predict_components();
                end
                else
                begin
                    n = active_vertices();
                    if (cmd.from_vertex < n && cmd.to_vertex < n)
                    begin
                        fwd_rows[cmd.from_vertex][cmd.to_vertex] = 1'b1;
                        rev_rows[cmd.to_vertex][cmd.from_vertex] = 1'b1;
                    end
                end
            end
            pending = component_q.size();
        end
    end

endmodule

// ===== tb/tb.sv =====
// Top of the SCC unit testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb;
    import scc_pkg::*;

    localparam int StallLimit = 5000;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    scc_in_t     cmd;
    logic        res_valid;
    scc_out_t    res;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;
    int          idle_pct;
    int          quiet_cycles;
    int          n_now;

    strongly_connected_components_unit DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .res_valid(res_valid), .res(res), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready)
    );

    scc_checker checker_i (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .res_valid(res_valid), .res(res), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .pready(pready),
        .fail_count(fail_count), .pending(pending)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Watchdog: cycles in which no word, result or register write is taken.
    always @(posedge clk)
    begin
        if ((start && !busy) || res_valid || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= StallLimit) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Drain: wait for every predicted word, then let the sequencer settle.
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0 || busy) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    // Register write while idle; setup then access phase.
    task automatic set_vertex_count(input int value);
        drain();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= {1'b0, REG_VERTEX_COUNT};
        pwdata  <= 32'(value);
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        n_now = (value & 31) < 1 ? 1 : ((value & 31) > 16 ? 16 : (value & 31));
    endtask

    // Offer one command word and hold it until it is taken.
    task automatic send_word(input logic kind, input int src, input int dst);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < idle_pct) @(posedge clk);
        end
        start            <= 1'b1;
        cmd.kind         <= kind;
        cmd.from_vertex  <= VertexBits'(src);
        cmd.to_vertex    <= VertexBits'(dst);
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    // Random phase: mostly edges inside the graph, some outside, runs now and then.
    task automatic random_phase(input int count);
        int roll;
        for (int i = 0; i < count; i++) begin
            roll = $urandom_range(99);
            if (roll < 14)
                send_word(KIND_RUN, $urandom_range(15), $urandom_range(15));
            else if (roll < 24)
                send_word(KIND_EDGE, $urandom_range(15), $urandom_range(15));
            else
                send_word(KIND_EDGE, $urandom_range(n_now - 1), $urandom_range(n_now - 1));
        end
        send_word(KIND_RUN, 0, 0);
    endtask

    initial
    begin
        quiet_cycles = 0;
        idle_pct = 0;
        n_now    = 16;
        rst_n    = 1'b0;
        start    = 1'b0;
        cmd      = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty graph, extreme vertices, self loop, duplicates, a cycle.
        send_word(KIND_RUN, 15, 15);
        send_word(KIND_EDGE, 0, 15);
        send_word(KIND_EDGE, 15, 0);
        send_word(KIND_EDGE, 0, 15);
        send_word(KIND_EDGE, 5, 5);
        send_word(KIND_EDGE, 1, 2);
        send_word(KIND_EDGE, 2, 3);
        send_word(KIND_EDGE, 3, 1);
        send_word(KIND_EDGE, 3, 4);
        send_word(KIND_RUN, 0, 0);

        // Lowered count: outside edges dropped, stored ones skipped by the run.
        set_vertex_count(4);
        send_word(KIND_EDGE, 3, 9);
        send_word(KIND_EDGE, 15, 0);
        send_word(KIND_EDGE, 0, 1);
        send_word(KIND_RUN, 0, 0);
        set_vertex_count(1);
        send_word(KIND_EDGE, 0, 0);
        send_word(KIND_EDGE, 0, 1);
        send_word(KIND_RUN, 0, 0);
        set_vertex_count(0);
        send_word(KIND_RUN, 0, 0);
        set_vertex_count(31);
        send_word(KIND_EDGE, 10, 14);
        send_word(KIND_RUN, 0, 0);
        drain();

        // Random phases at several counts and sender gaps.
        set_vertex_count(16);
        idle_pct = 0;
        random_phase(50);
        set_vertex_count($urandom_range(2, 15));
        idle_pct = 64;
        random_phase(50);
        set_vertex_count(16);
        idle_pct = 0;
        random_phase(40);
        set_vertex_count($urandom_range(0, 31));
        idle_pct = 25;
        random_phase(45);

        drain();
        repeat (100) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
